// ===== hw/rtl/nlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlc_pkg
// Types and constants for the numeric literal classifier: scan phases,
// result kinds, character codes and field widths.
// ----------------------------------------------------------------------------
package nlc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned MANT_W  = 64;
    localparam int unsigned LIMIT_W = 63;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned EXP_W   = 16;
    localparam int unsigned KIND_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 63'd2147483647;

    // character codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_E_LO  = 8'h65;
    localparam logic [BYTE_W-1:0] CH_E_UP  = 8'h45;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NAN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REAL = 2'd2;

    // scan phases, one-hot
    typedef enum logic [8:0] {
        PH_LEAD    = 9'b0_0000_0001,
        PH_SIGNED  = 9'b0_0000_0010,
        PH_INT     = 9'b0_0000_0100,
        PH_FRAC    = 9'b0_0000_1000,
        PH_EXPMARK = 9'b0_0001_0000,
        PH_EXPSIGN = 9'b0_0010_0000,
        PH_EXPDIG  = 9'b0_0100_0000,
        PH_TRAIL   = 9'b0_1000_0000,
        PH_BAD     = 9'b1_0000_0000
    } t_phase;

endpackage

// ===== hw/rtl/numeric_literal_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_literal_classifier
// Byte-serial lexer for decimal number literals; one result per string.
// ----------------------------------------------------------------------------
// Feed a zero-terminated text one byte per request on the text channel. Every
// byte is taken into an input register and scanned from there by
// the phase machine, which updates sign, mantissa (times ten plus digit, with
// saturation), fraction digit count and exponent digits. The zero byte closes
// the string: it produces exactly one request on the result channel (kind 0
// not a number, 1 integer, 2 real; sign; 64-bit mantissa; 16-bit signed
// decimal exponent; overflow flag) and clears the scan state, so the next
// string may follow immediately. Value = mantissa * 10^decimal_exponent.
// Throughput is one byte per clock while the text channel is not stalled. A
// string's result passes through the input register, then the result register,
// before it can be taken on the result channel. The text channel only
// stalls when a zero byte meets a result register that is still full and not
// being read. The integer limit register may be written at any time through
// the configuration channel but should be changed only when no string is in
// flight.
// ----------------------------------------------------------------------------
module numeric_literal_classifier
    import nlc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LIMIT_W-1:0]  i_cfg_integer_limit,

    // text input
    input  logic                i_text_valid,
    output logic                o_text_ready,
    input  logic [BYTE_W-1:0]   i_text_byte,

    // result output
    output logic                o_result_valid,
    input  logic                i_result_ready,
    output logic [KIND_W-1:0]   o_kind,
    output logic                o_is_negative,
    output logic [MANT_W-1:0]   o_mantissa,
    output logic signed [EXP_W-1:0] o_decimal_exponent,
    output logic                o_overflowed
);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_integer_limit;
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              advance;
    logic              is_end;

    assign is_end       = (r_in_byte == CH_NUL);
    // non-zero bytes never stall; the end byte needs room in the result reg
    assign advance      = r_in_vld && (!is_end || !o_result_valid || i_result_ready);
    assign o_text_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_text_ready) begin
            r_in_vld <= i_text_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_text_ready && i_text_valid) begin
            r_in_byte <= i_text_byte;
        end
    end

    // ------------------------------------------------------------------
    // scan state
    // ------------------------------------------------------------------
    t_phase             r_phase,     n_phase;
    logic               r_minus,     n_minus;
    logic               r_int_seen,  n_int_seen;
    logic               r_real_seen, n_real_seen;
    logic [MANT_W-1:0]  r_acc,       n_acc;
    logic [COUNT_W-1:0] r_frac,      n_frac;
    logic               r_exp_minus, n_exp_minus;
    logic [COUNT_W-1:0] r_exp,       n_exp;
    logic               r_sat,       n_sat;

    // character classes
    logic              c_dig, c_blank, c_emark, c_dot, c_minus, c_plus;
    logic [3:0]        c_val;

    assign c_dig   = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign c_blank = (r_in_byte == CH_SPACE) ||
                     ((r_in_byte >= CH_TAB) && (r_in_byte <= CH_CR));
    assign c_emark = (r_in_byte == CH_E_LO) || (r_in_byte == CH_E_UP);
    assign c_dot   = (r_in_byte == CH_DOT);
    assign c_minus = (r_in_byte == CH_MINUS);
    assign c_plus  = (r_in_byte == CH_PLUS);
    assign c_val   = r_in_byte[3:0];

    // acc*10 + d as shift-add; carry-out above 64 bits means saturation
    logic [MANT_W+3:0] mant_sum;
    logic              mant_ovf;
    assign mant_sum = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + {{(MANT_W){1'b0}}, c_val};
    assign mant_ovf = |mant_sum[MANT_W+3:MANT_W];

    logic [COUNT_W+3:0] exp_sum;
    logic               exp_ovf;
    assign exp_sum = ({4'b0, r_exp} << 3) + ({4'b0, r_exp} << 1)
                   + {{(COUNT_W){1'b0}}, c_val};
    assign exp_ovf = |exp_sum[COUNT_W+3:COUNT_W];

    logic do_mant, do_exp, do_frac;

    always_comb begin
        n_phase     = r_phase;
        n_minus     = r_minus;
        n_int_seen  = r_int_seen;
        n_real_seen = r_real_seen;
        n_exp_minus = r_exp_minus;
        do_mant     = 1'b0;
        do_exp      = 1'b0;
        do_frac     = 1'b0;

        unique case (r_phase)
            PH_LEAD: begin
                priority if (c_blank) begin
                end else if (c_minus) begin
                    n_minus = 1'b1;
                    n_phase = PH_SIGNED;
                end else if (c_plus) begin
                    n_phase = PH_SIGNED;
                end else if (c_dig) begin
                    do_mant    = 1'b1;
                    n_int_seen = 1'b1;
                    n_phase    = PH_INT;
                end else if (c_dot) begin
                    n_real_seen = 1'b1;
                    n_phase     = PH_FRAC;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_SIGNED: begin
                priority if (c_blank) begin
                end else if (c_dig) begin
                    do_mant    = 1'b1;
                    n_int_seen = 1'b1;
                    n_phase    = PH_INT;
                end else if (c_dot) begin
                    n_real_seen = 1'b1;
                    n_phase     = PH_FRAC;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_INT: begin
                priority if (c_dig) begin
                    do_mant = 1'b1;
                end else if (c_dot) begin
                    n_real_seen = 1'b1;
                    n_phase     = PH_FRAC;
                end else if (c_emark) begin
                    n_real_seen = 1'b1;
                    n_phase     = PH_EXPMARK;
                end else if (c_blank) begin
                    n_phase = PH_TRAIL;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_FRAC: begin
                priority if (c_dig) begin
                    do_mant = 1'b1;
                    do_frac = 1'b1;
                end else if (!r_int_seen && (r_frac == '0)) begin
                    // lone dot
                    n_phase = PH_BAD;
                end else if (c_emark) begin
                    n_phase = PH_EXPMARK;
                end else if (c_blank) begin
                    n_phase = PH_TRAIL;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_EXPMARK: begin
                priority if (c_minus) begin
                    n_exp_minus = 1'b1;
                    n_phase     = PH_EXPSIGN;
                end else if (c_plus) begin
                    n_phase = PH_EXPSIGN;
                end else if (c_dig) begin
                    do_exp  = 1'b1;
                    n_phase = PH_EXPDIG;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_EXPSIGN: begin
                if (c_dig) begin
                    do_exp  = 1'b1;
                    n_phase = PH_EXPDIG;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_EXPDIG: begin
                priority if (c_dig) begin
                    do_exp = 1'b1;
                end else if (c_blank) begin
                    n_phase = PH_TRAIL;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_TRAIL: begin
                if (!c_blank) begin
                    n_phase = PH_BAD;
                end
            end
            default: begin
                n_phase = PH_BAD;
            end
        endcase

        n_acc  = r_acc;
        n_exp  = r_exp;
        n_frac = r_frac;
        n_sat  = r_sat;
        if (do_mant) begin
            n_acc = mant_ovf ? '1 : mant_sum[MANT_W-1:0];
            n_sat = n_sat | mant_ovf;
        end
        if (do_exp) begin
            n_exp = exp_ovf ? '1 : exp_sum[COUNT_W-1:0];
            n_sat = n_sat | exp_ovf;
        end
        if (do_frac) begin
            if (r_frac == '1) begin
                n_sat = 1'b1;
            end else begin
                n_frac = r_frac + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && is_end)) begin
            r_phase     <= PH_LEAD;
            r_minus     <= 1'b0;
            r_int_seen  <= 1'b0;
            r_real_seen <= 1'b0;
            r_acc       <= '0;
            r_frac      <= '0;
            r_exp_minus <= 1'b0;
            r_exp       <= '0;
            r_sat       <= 1'b0;
        end else if (advance) begin
            r_phase     <= n_phase;
            r_minus     <= n_minus;
            r_int_seen  <= n_int_seen;
            r_real_seen <= n_real_seen;
            r_acc       <= n_acc;
            r_frac      <= n_frac;
            r_exp_minus <= n_exp_minus;
            r_exp       <= n_exp;
            r_sat       <= n_sat;
        end
    end

    // ------------------------------------------------------------------
    // result formation from the state left before the end byte
    // ------------------------------------------------------------------
    localparam int unsigned EW = COUNT_W + 2;

    logic                 res_ok;
    logic signed [EW-1:0] e_signed;
    logic signed [EW-1:0] e_full;
    logic                 e_hi, e_lo;
    logic [EXP_W-1:0]     e_sat;
    logic [KIND_W-1:0]    res_kind;

    assign res_ok = (r_phase == PH_INT) || (r_phase == PH_EXPDIG) ||
                    (r_phase == PH_TRAIL) ||
                    ((r_phase == PH_FRAC) && (r_int_seen || (r_frac != '0)));

    assign e_signed = r_exp_minus ? -$signed({2'b00, r_exp}) : $signed({2'b00, r_exp});
    assign e_full   = e_signed - $signed({2'b00, r_frac});
    assign e_hi     = (e_full > $signed(EW'(32767)));
    assign e_lo     = (e_full < -$signed(EW'(32768)));
    assign e_sat    = e_hi ? 16'h7FFF : (e_lo ? 16'h8000 : e_full[EXP_W-1:0]);

    assign res_kind = (r_real_seen || (r_acc > {1'b0, r_limit})) ? KIND_REAL : KIND_INT;

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic              r_out_vld;
    logic [KIND_W-1:0] r_kind;
    logic              r_neg;
    logic [MANT_W-1:0] r_mant;
    logic [EXP_W-1:0]  r_dexp;
    logic              r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && is_end) begin
            r_out_vld <= 1'b1;
        end else if (i_result_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_end) begin
            if (res_ok) begin
                r_kind <= res_kind;
                r_neg  <= r_minus;
                r_mant <= r_acc;
                r_dexp <= e_sat;
                r_ovf  <= r_sat | e_hi | e_lo;
            end else begin
                r_kind <= KIND_NAN;
                r_neg  <= 1'b0;
                r_mant <= '0;
                r_dexp <= '0;
                r_ovf  <= 1'b0;
            end
        end
    end

    assign o_result_valid     = r_out_vld;
    assign o_kind             = r_kind;
    assign o_is_negative      = r_neg;
    assign o_mantissa         = r_mant;
    assign o_decimal_exponent = r_dexp;
    assign o_overflowed       = r_ovf;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_nan_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_kind == KIND_NAN)) |->
        ((r_mant == '0) && (r_dexp == '0) && !r_neg && !r_ovf))
        else $error("not-a-number result carries nonzero fields");

    a_end_clears_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_end) |=>
        ((r_phase == PH_LEAD) && (r_acc == '0) && (r_frac == '0) && !r_sat))
        else $error("scan state not cleared after end of string");

    a_int_phase_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_INT) |-> r_int_seen)
        else $error("integer phase without an integer digit");

    a_int_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_kind == KIND_INT)) |-> (r_mant <= {1'b0, r_limit}))
        else $error("integer result above the integer limit");

    a_only_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |-> (is_end && r_out_vld))
        else $error("input stalled on a byte that produces no result");

endmodule

// ===== verif/numeric_literal_classifier_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_literal_classifier_test
// Self-checking bench for the byte-serial decimal literal lexer.
// ----------------------------------------------------------------------------
// Strings go in one byte per request, each closed by a zero byte. A predictor
// in this module scans the same bytes and queues the literal expected for
// every zero byte. The monitor compares every result request field by field
// with the oldest queued literal. A short table of hand-picked strings comes
// first, then random strings, mostly well formed, under several integer
// limits. Both channels stall at random.
// ----------------------------------------------------------------------------
module numeric_literal_classifier_test;
    import nlc_pkg::*;

    // no request moves on any channel for this long: the block has hung
    localparam int QUIET_LIMIT = 1000;

    // one classified literal, as carried by the result channel
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              neg;
        logic [MANT_W-1:0] mant;
        logic [EXP_W-1:0]  dexp;
        logic              ovf;
    } t_literal;

    // directed string; want is only used where typed is set
    typedef struct {
        string    text;
        bit       typed;
        t_literal want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [LIMIT_W-1:0] i_cfg_integer_limit = '0;
    logic               i_text_valid = 1'b0;
    logic               o_text_ready;
    logic [BYTE_W-1:0]  i_text_byte = '0;
    logic               o_result_valid;
    logic               i_result_ready = 1'b0;
    logic [KIND_W-1:0]  o_kind;
    logic               o_is_negative;
    logic [MANT_W-1:0]  o_mantissa;
    logic signed [EXP_W-1:0] o_decimal_exponent;
    logic               o_overflowed;

    numeric_literal_classifier dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_integer_limit (i_cfg_integer_limit),
        .i_text_valid        (i_text_valid),
        .o_text_ready        (o_text_ready),
        .i_text_byte         (i_text_byte),
        .o_result_valid      (o_result_valid),
        .i_result_ready      (i_result_ready),
        .o_kind              (o_kind),
        .o_is_negative       (o_is_negative),
        .o_mantissa          (o_mantissa),
        .o_decimal_exponent  (o_decimal_exponent),
        .o_overflowed        (o_overflowed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the scanner and the limit register
    // ------------------------------------------------------------------------
    t_phase             scan_ph;
    logic               neg_sign;
    logic               int_seen;
    logic               real_seen;
    logic [MANT_W-1:0]  mant_acc;
    logic [COUNT_W-1:0] frac_cnt;
    logic               exp_neg;
    logic [COUNT_W-1:0] exp_acc;
    logic               sat_seen;
    logic [LIMIT_W-1:0] limit_reg;

    t_literal      pending_literals[$];   // one per zero byte, oldest first
    t_row          rows[$];
    logic [7:0]    text_buf[$];           // string being built for sending
    int            mismatch_count = 0;
    int            quiet_cycles = 0;
    int            sent_bytes = 0;
    int            stall_left = 0;
    int            calm_left = 0;
    t_literal      oldest;

    function automatic void clear_scan();
        scan_ph   = PH_LEAD;
        neg_sign  = 1'b0;
        int_seen  = 1'b0;
        real_seen = 1'b0;
        mant_acc  = '0;
        frac_cnt  = '0;
        exp_neg   = 1'b0;
        exp_acc   = '0;
        sat_seen  = 1'b0;
    endfunction

    // mantissa sticks at all ones once the next digit would not fit
    function automatic void add_mant_digit(logic [3:0] d);
        if (mant_acc > (64'hFFFF_FFFF_FFFF_FFFF - {60'd0, d}) / 64'd10) begin
            mant_acc = 64'hFFFF_FFFF_FFFF_FFFF;
            sat_seen = 1'b1;
        end else begin
            mant_acc = mant_acc * 64'd10 + {60'd0, d};
        end
    endfunction

    function automatic void add_exp_digit(logic [3:0] d);
        logic [31:0] v;
        v = {16'd0, exp_acc} * 32'd10 + {28'd0, d};
        if (v > 32'd65535) begin
            v = 32'd65535;
            sat_seen = 1'b1;
        end
        exp_acc = v[COUNT_W-1:0];
    endfunction

    // Advance the predictor by one accepted byte. On the zero byte the
    // literal is finished and the scanner starts over.
    task automatic scan_byte(input logic [7:0] c, output logic done, output t_literal res);
        logic dig;
        logic blank;
        logic emark;
        int   e;
        int   fc;
        dig   = (c >= CH_ZERO) && (c <= CH_NINE);
        blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        emark = (c == CH_E_LO) || (c == CH_E_UP);
        done  = 1'b0;
        res   = '0;
        if (c == CH_NUL) begin
            done = 1'b1;
            // anything that did not end in a digit run, a dot after digits or trailing
            // blanks, and a lone dot, reads as not a number with all fields zero
            if (scan_ph == PH_INT || scan_ph == PH_EXPDIG || scan_ph == PH_TRAIL ||
                    (scan_ph == PH_FRAC && (int_seen || frac_cnt != 0))) begin
                e  = exp_acc;
                fc = frac_cnt;
                if (exp_neg) begin
                    e = -e;
                end
                e = e - fc;
                res.ovf = sat_seen;
                if (e > 32767) begin
                    e = 32767;
                    res.ovf = 1'b1;
                end
                if (e < -32768) begin
                    e = -32768;
                    res.ovf = 1'b1;
                end
                // limit is checked against the magnitude, sign aside
                res.kind = (real_seen || mant_acc > {1'b0, limit_reg}) ? KIND_REAL : KIND_INT;
                res.neg  = neg_sign;
                res.mant = mant_acc;
                res.dexp = e[EXP_W-1:0];
            end
            clear_scan();
        end else begin
            case (scan_ph)
                PH_LEAD, PH_SIGNED: begin
                    // a sign only counts in the leading blanks
                    if (blank) begin
                        scan_ph = scan_ph;
                    end else if (scan_ph == PH_LEAD && c == CH_MINUS) begin
                        neg_sign = 1'b1;
                        scan_ph  = PH_SIGNED;
                    end else if (scan_ph == PH_LEAD && c == CH_PLUS) begin
                        scan_ph = PH_SIGNED;
                    end else if (dig) begin
                        add_mant_digit(c[3:0]);
                        int_seen = 1'b1;
                        scan_ph  = PH_INT;
                    end else if (c == CH_DOT) begin
                        real_seen = 1'b1;
                        scan_ph   = PH_FRAC;
                    end else begin
                        scan_ph = PH_BAD;
                    end
                end
                PH_INT: begin
                    if (dig) begin
                        add_mant_digit(c[3:0]);
                    end else if (c == CH_DOT) begin
                        real_seen = 1'b1;
                        scan_ph   = PH_FRAC;
                    end else if (emark) begin
                        real_seen = 1'b1;
                        scan_ph   = PH_EXPMARK;
                    end else if (blank) begin
                        scan_ph = PH_TRAIL;
                    end else begin
                        scan_ph = PH_BAD;
                    end
                end
                PH_FRAC: begin
                    if (dig) begin
                        add_mant_digit(c[3:0]);
                        if (frac_cnt == 16'hFFFF) begin
                            sat_seen = 1'b1;
                        end else begin
                            frac_cnt = frac_cnt + 1'b1;
                        end
                    end else if (!int_seen && frac_cnt == 0) begin
                        scan_ph = PH_BAD;
                    end else if (emark) begin
                        scan_ph = PH_EXPMARK;
                    end else if (blank) begin
                        scan_ph = PH_TRAIL;
                    end else begin
                        scan_ph = PH_BAD;
                    end
                end
                PH_EXPMARK: begin
                    if (c == CH_MINUS) begin
                        exp_neg = 1'b1;
                        scan_ph = PH_EXPSIGN;
                    end else if (c == CH_PLUS) begin
                        scan_ph = PH_EXPSIGN;
                    end else if (dig) begin
                        add_exp_digit(c[3:0]);
                        scan_ph = PH_EXPDIG;
                    end else begin
                        scan_ph = PH_BAD;
                    end
                end
                PH_EXPSIGN: begin
                    if (dig) begin
                        add_exp_digit(c[3:0]);
                        scan_ph = PH_EXPDIG;
                    end else begin
                        scan_ph = PH_BAD;
                    end
                end
                PH_EXPDIG: begin
                    if (dig) begin
                        add_exp_digit(c[3:0]);
                    end else if (blank) begin
                        scan_ph = PH_TRAIL;
                    end else begin
                        scan_ph = PH_BAD;
                    end
                end
                PH_TRAIL: begin
                    if (!blank) begin
                        scan_ph = PH_BAD;
                    end
                end
                default: begin
                    // bad character: wait for the zero byte
                    scan_ph = PH_BAD;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Helpers for building and sending strings
    // ------------------------------------------------------------------------
    // mostly back to back, now and then a long hold-off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_row(string text);
        t_row r;
        r.text  = text;
        r.typed = 1'b0;
        r.want  = '0;
        rows.push_back(r);
    endfunction

    function automatic void add_known(string text, logic [KIND_W-1:0] kind, logic neg,
                                      logic [MANT_W-1:0] mant, logic [EXP_W-1:0] dexp,
                                      logic ovf);
        t_row r;
        r.text      = text;
        r.typed     = 1'b1;
        r.want.kind = kind;
        r.want.neg  = neg;
        r.want.mant = mant;
        r.want.dexp = dexp;
        r.want.ovf  = ovf;
        rows.push_back(r);
    endfunction

    function automatic void load_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            text_buf.push_back(s[i]);
        end
    endfunction

    function automatic void push_digits(int n);
        repeat (n) text_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    // space, or one of tab / LF / VT / FF / CR
    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? CH_SPACE : 8'(CH_TAB + r - 1);
    endfunction

    function automatic int pick_run();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 4);
        if (r < 90) return $urandom_range(5, 12);
        return $urandom_range(17, 22);    // around mantissa overflow
    endfunction

    // Random string: mostly the full grammar with random content, some of it
    // damaged by one byte, the rest plain noise. No zero byte inside.
    function automatic void make_random_text();
        int          style;
        int          pos;
        logic [63:0] near;
        text_buf.delete();
        style = $urandom_range(0, 99);
        if (style < 8) begin
            repeat ($urandom_range(0, 6)) text_buf.push_back(8'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) text_buf.push_back(pick_blank());
            case ($urandom_range(0, 3))
                0: text_buf.push_back(CH_MINUS);
                1: text_buf.push_back(CH_PLUS);
                default: ;
            endcase
            if ($urandom_range(0, 7) == 0) text_buf.push_back(pick_blank());
            if ($urandom_range(0, 5) == 0) begin
                // just around the integer limit
                near = {1'b0, limit_reg} + $urandom_range(0, 2) - 1;
                load_text($sformatf("%0d", near));
            end else if ($urandom_range(0, 4) != 0) begin
                push_digits(pick_run());
            end
            if ($urandom_range(0, 2) == 0) begin
                text_buf.push_back(CH_DOT);
                push_digits($urandom_range(0, 4));
            end
            if ($urandom_range(0, 3) == 0) begin
                text_buf.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
                case ($urandom_range(0, 2))
                    0: text_buf.push_back(CH_MINUS);
                    1: text_buf.push_back(CH_PLUS);
                    default: ;
                endcase
                case ($urandom_range(0, 9))
                    0: push_digits(0);
                    1: push_digits($urandom_range(5, 6));
                    default: push_digits($urandom_range(1, 3));
                endcase
            end
            repeat ($urandom_range(0, 2)) text_buf.push_back(pick_blank());
            if (style < 25) begin
                pos = (text_buf.size() > 0) ? $urandom_range(0, text_buf.size() - 1) : 0;
                case ($urandom_range(0, 2))
                    0: begin
                        if (text_buf.size() > 0) text_buf[pos] = 8'($urandom_range(1, 255));
                    end
                    1: text_buf.insert(pos, 8'($urandom_range(1, 255)));
                    default: begin
                        if (text_buf.size() > 0) text_buf.delete(pos);
                    end
                endcase
            end
        end
    endfunction

    // Send text_buf plus its zero byte. Each accepted byte goes through the
    // predictor; the zero byte queues a literal (the typed one if given).
    // Returns at a falling edge with text valid still high.
    task automatic send_text(input bit typed, input t_literal want, input bit calm);
        int       gap;
        logic     done;
        t_literal got;
        text_buf.push_back(CH_NUL);
        foreach (text_buf[i]) begin
            gap = calm ? 0 : pick_gap();
            if (gap > 0) begin
                i_text_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_text_valid <= 1'b1;
            i_text_byte  <= text_buf[i];
            do @(posedge i_clk); while (!o_text_ready);
            scan_byte(text_buf[i], done, got);
            if (done) pending_literals.push_back(typed ? want : got);
            sent_bytes++;
            @(negedge i_clk);
        end
    endtask

    // Sender holds off until every literal is back, then also waits out the input
    // and result registers of the block in case a byte is still being scanned.
    task automatic wait_drained();
        i_text_valid <= 1'b0;
        while (pending_literals.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        wait_drained();
        i_cfg_valid         <= 1'b1;
        i_cfg_integer_limit <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        limit_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_strings(input int budget);
        int  start;
        bit  calm;
        start = sent_bytes;
        while (sent_bytes - start < budget) begin
            make_random_text();
            calm = ($urandom_range(0, 9) == 0);
            send_text(1'b0, '0, calm);
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, with calm stretches of steady ready
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (calm_left > 0) begin
            calm_left      <= calm_left - 1;
            i_result_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left     <= stall_left - 1;
            i_result_ready <= 1'b0;
        end else if ($urandom_range(0, 99) == 0) begin
            calm_left      <= $urandom_range(50, 300);
            i_result_ready <= 1'b1;
        end else begin
            stall_left     <= pick_gap();
            i_result_ready <= 1'b1;
        end
    end

    // each result request against the oldest queued literal
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid && i_result_ready) begin
            if (pending_literals.size() == 0) begin
                report_mismatch($sformatf("unexpected result: kind %0d mantissa %0d",
                                          o_kind, o_mantissa));
            end else begin
                oldest = pending_literals.pop_front();
                if (o_kind !== oldest.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", o_kind, oldest.kind));
                if (o_is_negative !== oldest.neg)
                    report_mismatch($sformatf("is_negative %0b, want %0b",
                                              o_is_negative, oldest.neg));
                if (o_mantissa !== oldest.mant)
                    report_mismatch($sformatf("mantissa %0d, want %0d",
                                              o_mantissa, oldest.mant));
                if (o_decimal_exponent !== oldest.dexp)
                    report_mismatch($sformatf("decimal_exponent %0d, want %0d",
                                              o_decimal_exponent, $signed(oldest.dexp)));
                if (o_overflowed !== oldest.ovf)
                    report_mismatch($sformatf("overflowed %0b, want %0b",
                                              o_overflowed, oldest.ovf));
            end
        end
    end

    // hang detector: any request on any channel restarts the count
    always @(posedge i_clk) begin
        if ((i_text_valid && o_text_ready) || (o_result_valid && i_result_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [63:0] rnd_limit;
        clear_scan();
        limit_reg = LIMIT_RESET;

        // Directed strings under the reset limit. Typed rows are the ones
        // whose literal is obvious: empty text, zero, limit edges, mantissa and
        // exponent clamps, and the malformed cases.
        add_known("",                     KIND_NAN,  1'b0, 64'd0, 16'd0, 1'b0);
        add_known("0",                    KIND_INT,  1'b0, 64'd0, 16'd0, 1'b0);
        add_row("  -\t12 \n");
        add_row("+7.25e+3");
        add_row("-3000000000");
        add_known("2147483647",           KIND_INT,  1'b0, 64'd2147483647, 16'd0, 1'b0);
        add_known("2147483648",           KIND_REAL, 1'b0, 64'd2147483648, 16'd0, 1'b0);
        add_known("18446744073709551615", KIND_REAL, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
                  16'd0, 1'b0);
        // one past the top: mantissa clamps
        add_known("18446744073709551616", KIND_REAL, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
                  16'd0, 1'b1);
        add_known(".",                    KIND_NAN,  1'b0, 64'd0, 16'd0, 1'b0);
        add_row("5.");
        add_row(".5");
        add_known("1e",                   KIND_NAN,  1'b0, 64'd0, 16'd0, 1'b0);
        add_known("1e+",                  KIND_NAN,  1'b0, 64'd0, 16'd0, 1'b0);
        add_row("1E-7");
        // exponent digits clamp at 65535, then the exponent at +32767
        add_known("1e99999",              KIND_REAL, 1'b0, 64'd1, 16'h7FFF, 1'b1);
        add_row("1e-32768");
        add_known("1e-40000",             KIND_REAL, 1'b0, 64'd1, 16'h8000, 1'b1);
        add_known("12x3",                 KIND_NAN,  1'b0, 64'd0, 16'd0, 1'b0);
        add_known("\377",                 KIND_NAN,  1'b0, 64'd0, 16'd0, 1'b0);
        add_row("- 5");
        add_known("+-5",                  KIND_NAN,  1'b0, 64'd0, 16'd0, 1'b0);
        add_known(".e5",                  KIND_NAN,  1'b0, 64'd0, 16'd0, 1'b0);
        add_row("5.e3");
        add_row("1.5 \013\014\015");
        add_known("7 8",                  KIND_NAN,  1'b0, 64'd0, 16'd0, 1'b0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            text_buf.delete();
            load_text(rows[i].text);
            send_text(rows[i].typed, rows[i].want, 1'b0);
        end
        random_strings(180);

        // every number but zero is real
        write_limit('0);
        random_strings(180);

        // only a dot, an exponent or a mantissa of 2^63 or more makes a number real
        write_limit({LIMIT_W{1'b1}});
        random_strings(180);

        write_limit(LIMIT_RESET);
        random_strings(180);

        rnd_limit = {$urandom, $urandom};
        write_limit(rnd_limit[LIMIT_W-1:0]);
        random_strings(180);

        write_limit(63'd999);
        random_strings(180);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
